@@ hdl/igr_pkg.sv @@
// igr_pkg: shared types, constants and the read/multiply step table
// for the interpolated image gradient core
// no dependencies
`default_nettype none

package igr_pkg;

    // default sizes
    localparam int MAX_DIM_DEF    = 256;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // result field width and saturation limits
    localparam int GRAD_W   = 24;
    localparam int GRAD_MAX = 8388607;
    localparam int GRAD_MIN = -8388608;

    // configuration registers
    localparam int         DIM_W     = 9;
    localparam logic [8:0] DIM_RESET = 9'd256;
    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    // request kinds and result status
    localparam logic CMD_WRITE      = 1'b0;
    localparam logic CMD_QUERY      = 1'b1;
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul;    // load a new product
        logic acc;    // fold that product into the accumulator
        logic first;  // restart the sum with this product
        logic neg;    // subtract instead of add
    } mac_ctl_t;

    // one gradient step: pixel offset (plus one) and its signed weight
    typedef struct packed {
        logic [1:0] dc;
        logic [1:0] dr;
        logic [1:0] wsel;  // 0: wx0*wy0, 1: fx*wy0, 2: wx0*fy, 3: fx*fy
        logic       neg;
    } step_t;

    function automatic int mac_a_w(input int pix_bits, input int frac_bits);
        return ((pix_bits > frac_bits + 1) ? pix_bits : frac_bits + 1) + 1;
    endfunction

    function automatic int mac_b_w(input int frac_bits);
        return 2 * frac_bits + 2;
    endfunction

    function automatic int acc_w(input int pix_bits, input int frac_bits);
        return 2 * frac_bits + pix_bits + 2;
    endfunction

    // steps 0..7 build the x sum, steps 8..15 the y sum
    function automatic step_t step_info(input logic [3:0] s);
        step_t r;
        case (s)
            4'd0:  r = '{dc: 2'd2, dr: 2'd1, wsel: 2'd0, neg: 1'b0};
            4'd1:  r = '{dc: 2'd0, dr: 2'd1, wsel: 2'd0, neg: 1'b1};
            4'd2:  r = '{dc: 2'd3, dr: 2'd1, wsel: 2'd1, neg: 1'b0};
            4'd3:  r = '{dc: 2'd1, dr: 2'd1, wsel: 2'd1, neg: 1'b1};
            4'd4:  r = '{dc: 2'd2, dr: 2'd2, wsel: 2'd2, neg: 1'b0};
            4'd5:  r = '{dc: 2'd0, dr: 2'd2, wsel: 2'd2, neg: 1'b1};
            4'd6:  r = '{dc: 2'd3, dr: 2'd2, wsel: 2'd3, neg: 1'b0};
            4'd7:  r = '{dc: 2'd1, dr: 2'd2, wsel: 2'd3, neg: 1'b1};
            4'd8:  r = '{dc: 2'd1, dr: 2'd2, wsel: 2'd0, neg: 1'b0};
            4'd9:  r = '{dc: 2'd1, dr: 2'd0, wsel: 2'd0, neg: 1'b1};
            4'd10: r = '{dc: 2'd1, dr: 2'd3, wsel: 2'd2, neg: 1'b0};
            4'd11: r = '{dc: 2'd1, dr: 2'd1, wsel: 2'd2, neg: 1'b1};
            4'd12: r = '{dc: 2'd2, dr: 2'd2, wsel: 2'd1, neg: 1'b0};
            4'd13: r = '{dc: 2'd2, dr: 2'd0, wsel: 2'd1, neg: 1'b1};
            4'd14: r = '{dc: 2'd2, dr: 2'd3, wsel: 2'd3, neg: 1'b0};
            4'd15: r = '{dc: 2'd2, dr: 2'd1, wsel: 2'd3, neg: 1'b1};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/interpolated_image_gradient_core.sv @@
// interpolated image gradient core: pixel store, query sequencer and config port
// depends on igr_pkg, igr_store and igr_mac
// a pixel write or an outside point sets the result register on accept; an interior query
//   runs 4 weight products, then 16 single-port store reads into the one shared multiplier
// throughput: writes, outside points back to back if m_tready; interior queries block input
// reset: aresetn synchronous active low clears control and the size registers, not the store
`default_nettype none

module interpolated_image_gradient_core
    import igr_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_col[7:0], pixel_row[15:8], pixel_value[31:16], point_x[47:32], point_y[63:48]
    input  wire logic [63:0] s_tdata,
    // cmd[0]
    input  wire logic        s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // grad_x[23:0], grad_y[47:24]
    output logic [47:0]      m_tdata,
    // status[0]
    output logic             m_tuser,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int CW     = $clog2(MAX_DIM);          // column / row address bits
    localparam int MEM_AW = 2 * CW;
    localparam int IXW    = (16 - FRAC_BITS > 0) ? 16 - FRAC_BITS : 1;
    localparam int DIMW   = $clog2(MAX_DIM + 1);
    localparam int LW0    = (IXW > DIM_W) ? IXW : DIM_W;
    localparam int LW     = ((LW0 > DIMW) ? LW0 : DIMW) + 1;  // bounds compare width
    localparam int AW     = mac_a_w(PIXEL_BITS, FRAC_BITS);
    localparam int BW     = mac_b_w(FRAC_BITS);
    localparam int ACCW   = acc_w(PIXEL_BITS, FRAC_BITS);
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int SW     = ACCW - FRAC_BITS - 1;
    localparam int CMPW   = (SW > GRAD_W) ? SW : GRAD_W;

    localparam logic signed [CMPW-1:0] GMAX = CMPW'(GRAD_MAX);
    localparam logic signed [CMPW-1:0] GMIN = CMPW'(GRAD_MIN);
    localparam logic [FRAC_BITS:0]     WONE = {1'b1, {FRAC_BITS{1'b0}}};

    // sequencer timeline, counted from the first cycle after the request
    localparam int          CNT_W     = 5;
    localparam logic [4:0]  WGT_LAST  = 5'd3;   // weight products issued 0..3
    localparam logic [4:0]  CAP_FIRST = 5'd1;   // weight products land 1..4
    localparam logic [4:0]  CAP_LAST  = 5'd4;
    localparam logic [4:0]  RD_FIRST  = 5'd4;   // store reads issued 4..19
    localparam logic [4:0]  MAC_FIRST = 5'd5;   // pixel products issued 5..20
    localparam logic [4:0]  MAC_LAST  = 5'd20;
    localparam logic [4:0]  SX_AT     = 5'd14;  // x sum complete in accumulator
    localparam logic [4:0]  SY_AT     = 5'd22;  // y sum complete, result out
    localparam logic [3:0]  STEP_X0   = 4'd0;
    localparam logic [3:0]  STEP_Y0   = 4'd8;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    // ------------------------------------------------------------------
    // request fields
    // ------------------------------------------------------------------
    logic               cmd;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
    logic signed [15:0] pixel_value;
    logic [15:0]        point_x;
    logic [15:0]        point_y;

    assign cmd         = s_tuser;
    assign pixel_col   = s_tdata[7:0];
    assign pixel_row   = s_tdata[15:8];
    assign pixel_value = s_tdata[31:16];
    assign point_x     = s_tdata[47:32];
    assign point_y     = s_tdata[63:48];

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // interior check on the incoming point
    // ------------------------------------------------------------------
    logic [IXW-1:0] ix;
    logic [IXW-1:0] iy;
    logic [LW-1:0]  ixl;
    logic [LW-1:0]  iyl;
    logic [LW-1:0]  w_lim;
    logic [LW-1:0]  h_lim;
    logic           in_interior;

    always_comb begin
        ix    = IXW'(point_x >> FRAC_BITS);
        iy    = IXW'(point_y >> FRAC_BITS);
        ixl   = LW'(ix);
        iyl   = LW'(iy);
        // store size caps the registers
        w_lim = (LW'(width_reg) < LW'(MAX_DIM)) ? LW'(width_reg) : LW'(MAX_DIM);
        h_lim = (LW'(height_reg) < LW'(MAX_DIM)) ? LW'(height_reg) : LW'(MAX_DIM);
        in_interior = (ixl != '0) && (ixl + LW'(3) <= w_lim)
                   && (iyl != '0) && (iyl + LW'(3) <= h_lim);
    end

    // ------------------------------------------------------------------
    // sequencer state and latched query
    // ------------------------------------------------------------------
    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [FRAC_BITS-1:0]   fx_reg;
    logic [FRAC_BITS-1:0]   fy_reg;
    logic [CW-1:0]          col0_reg;   // column of the left neighbor, ix-1
    logic [CW-1:0]          row0_reg;   // row of the upper neighbor, iy-1
    logic [WGT_W-1:0]       wgt_reg [0:3];
    logic [GRAD_W-1:0]      gx_reg;
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;
    logic                   m_tuser_reg;

    logic accept;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // pixel store: writes while idle, neighbor reads while running
    // ------------------------------------------------------------------
    logic                         wr_in_range;
    logic                         mem_we;
    logic [MEM_AW-1:0]            wr_addr;
    logic [MEM_AW-1:0]            rd_addr;
    logic [MEM_AW-1:0]            mem_addr;
    logic signed [PIXEL_BITS-1:0] wpix;
    logic signed [PIXEL_BITS-1:0] mem_rdata;
    step_t                        rd_step;

    always_comb begin
        wr_in_range = (int'(pixel_col) < MAX_DIM) && (int'(pixel_row) < MAX_DIM);
        mem_we      = accept && (cmd == CMD_WRITE) && wr_in_range;
        // wrap the pixel to the store width
        wpix        = PIXEL_BITS'(pixel_value);
        wr_addr     = {CW'(pixel_row), CW'(pixel_col)};
        rd_step     = step_info(4'(cnt_reg - RD_FIRST));
        rd_addr     = {row0_reg + CW'(rd_step.dr), col0_reg + CW'(rd_step.dc)};
        mem_addr    = (state_reg == ST_RUN) ? rd_addr : wr_addr;
    end

    igr_store #(
        .ADDR_W (MEM_AW),
        .DATA_W (PIXEL_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wpix),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // shared multiply-accumulate unit
    // cycles 0..3: the four bilinear weight products
    // cycles 5..20: pixel times signed weight, x sum then y sum
    // ------------------------------------------------------------------
    mac_ctl_t                 mac_ctl;
    logic signed [AW-1:0]     op_a;
    logic signed [BW-1:0]     op_b;
    logic signed [AW+BW-1:0]  prod;
    logic signed [ACCW-1:0]   acc;
    logic [FRAC_BITS:0]       wx0;
    logic [FRAC_BITS:0]       wy0;
    logic [3:0]               mac_idx;
    step_t                    mac_step;

    always_comb begin
        wx0      = WONE - {1'b0, fx_reg};
        wy0      = WONE - {1'b0, fy_reg};
        mac_idx  = 4'(cnt_reg - MAC_FIRST);
        mac_step = step_info(mac_idx);
        mac_ctl  = '0;
        op_a     = AW'(mem_rdata);
        op_b     = BW'(wgt_reg[mac_step.wsel]);
        if (state_reg == ST_RUN) begin
            if (cnt_reg <= WGT_LAST) begin
                // bit 0 picks fx over wx0, bit 1 picks fy over wy0
                mac_ctl.mul = 1'b1;
                op_a = AW'(cnt_reg[0] ? {1'b0, fx_reg} : wx0);
                op_b = BW'(cnt_reg[1] ? {1'b0, fy_reg} : wy0);
            end else if (cnt_reg inside {[MAC_FIRST:MAC_LAST]}) begin
                mac_ctl.mul   = 1'b1;
                mac_ctl.acc   = 1'b1;
                mac_ctl.first = (mac_idx == STEP_X0) || (mac_idx == STEP_Y0);
                mac_ctl.neg   = mac_step.neg;
            end
        end
    end

    igr_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod),
        .acc     (acc)
    );

    // arithmetic shift drops the extra fraction bits and the halving, then saturate
    function automatic logic [GRAD_W-1:0] finish_grad(input logic signed [ACCW-1:0] a);
        logic signed [CMPW-1:0] sh;
        sh = CMPW'(a >>> (FRAC_BITS + 1));
        if (sh > GMAX) begin
            return GRAD_W'(GMAX);
        end else if (sh < GMIN) begin
            return GRAD_W'(GMIN);
        end
        return GRAD_W'(sh);
    endfunction

    // ------------------------------------------------------------------
    // sequencer and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (cmd == CMD_WRITE) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= STATUS_DONE;
                        end else if (!in_interior) begin
                            // nothing is read for a flagged point
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= STATUS_OUTSIDE;
                        end else begin
                            fx_reg    <= point_x[FRAC_BITS-1:0];
                            fy_reg    <= point_y[FRAC_BITS-1:0];
                            col0_reg  <= CW'(ixl - LW'(1));
                            row0_reg  <= CW'(iyl - LW'(1));
                            cnt_reg   <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg >= CAP_FIRST && cnt_reg <= CAP_LAST) begin
                        wgt_reg[2'(cnt_reg - CAP_FIRST)] <= WGT_W'(prod);
                    end
                    if (cnt_reg == SX_AT) begin
                        gx_reg <= finish_grad(acc);
                    end
                    if (cnt_reg == SY_AT) begin
                        // result slot is empty here: requests wait for it
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {finish_grad(acc), gx_reg};
                        m_tuser_reg  <= STATUS_DONE;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ hdl/igr_store.sv @@
// igr_store: single-port pixel memory with registered read data
// depends on nothing
`default_nettype none

module igr_store #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/igr_mac.sv @@
// igr_mac: shared multiplier with registered product and accumulator
// depends on igr_pkg
`default_nettype none

module igr_mac
    import igr_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int AW   = mac_a_w(PIXEL_BITS, FRAC_BITS),
    localparam int BW   = mac_b_w(FRAC_BITS),
    localparam int ACCW = acc_w(PIXEL_BITS, FRAC_BITS)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire mac_ctl_t               ctl,
    input  wire logic signed [AW-1:0]   op_a,
    input  wire logic signed [BW-1:0]   op_b,
    output logic signed [AW+BW-1:0]     prod,
    output logic signed [ACCW-1:0]      acc
);

    mac_ctl_t                ctl_d_reg;
    logic signed [AW+BW-1:0] prod_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [ACCW-1:0]  acc_next;
    logic signed [ACCW-1:0]  term;
    logic signed [ACCW-1:0]  base;

    always_comb begin
        term     = ACCW'(prod_reg);
        base     = ctl_d_reg.first ? '0 : acc_reg;
        acc_next = ctl_d_reg.neg ? base - term : base + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_d_reg <= '0;
        end else begin
            ctl_d_reg <= ctl;
        end
        if (ctl.mul) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl_d_reg.acc) begin
            acc_reg <= acc_next;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire
